FILE: sv/wcd_pkg.sv
// Shared types, character codes and small arithmetic helpers for the HH:MM:SS display clock.
package wcd_pkg;

  typedef enum logic [1:0] {
    KIND_RESET = 2'd0,
    KIND_SET   = 2'd1,
    KIND_STOP  = 2'd2,
    KIND_TICK  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SEC  = 2'd1,
    PH_MIN  = 2'd2,
    PH_HOUR = 2'd3
  } set_phase_t;

  // Control for one digit cell: clear wins over load, load over step.
  typedef struct packed {
    logic clear;
    logic load;
    logic step;
  } digit_ctrl_t;

  // One character position of the output line.
  typedef struct packed {
    logic       valid;
    logic [6:0] ch;
    logic       last;
  } char_link_t;

  typedef struct packed {
    logic [1:0] quot;
    logic [5:0] rem;
  } mod60_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] units;
  } bcd_t;

  localparam int unsigned LINE_LEN   = 9;
  localparam int unsigned NUM_DIGITS = 6;

  localparam logic [6:0] CHAR_ZERO    = 7'h30;
  localparam logic [6:0] CHAR_COLON   = 7'h3A;
  localparam logic [6:0] CHAR_NEWLINE = 7'h0A;

  localparam logic [3:0] MAX_UNITS     = 4'd9;
  localparam logic [3:0] MAX_TENS_SM   = 4'd5;
  localparam logic [3:0] MAX_TENS_HR   = 4'd2;
  localparam logic [3:0] HOUR_WRAP_UNI = 4'd3;
  localparam logic [3:0] HOUR_WRAP_TEN = 4'd2;

  // Value below 180 split into sixties and remainder.
  function automatic mod60_t mod60(input logic [7:0] v);
    mod60_t r;
    if (v >= 8'd120) begin
      r.quot = 2'd2;
      r.rem  = 6'(v - 8'd120);
    end else if (v >= 8'd60) begin
      r.quot = 2'd1;
      r.rem  = 6'(v - 8'd60);
    end else begin
      r.quot = 2'd0;
      r.rem  = v[5:0];
    end
    return r;
  endfunction

  // Value below 144 reduced mod 24.
  function automatic logic [4:0] mod24(input logic [7:0] v);
    logic [7:0] r;
    if (v >= 8'd120)     r = v - 8'd120;
    else if (v >= 8'd96) r = v - 8'd96;
    else if (v >= 8'd72) r = v - 8'd72;
    else if (v >= 8'd48) r = v - 8'd48;
    else if (v >= 8'd24) r = v - 8'd24;
    else                 r = v;
    return r[4:0];
  endfunction

  // Binary below 60 to two decimal digits.
  function automatic bcd_t to_bcd(input logic [5:0] v);
    bcd_t r;
    if (v >= 6'd50) begin
      r.tens = 4'd5; r.units = 4'(v - 6'd50);
    end else if (v >= 6'd40) begin
      r.tens = 4'd4; r.units = 4'(v - 6'd40);
    end else if (v >= 6'd30) begin
      r.tens = 4'd3; r.units = 4'(v - 6'd30);
    end else if (v >= 6'd20) begin
      r.tens = 4'd2; r.units = 4'(v - 6'd20);
    end else if (v >= 6'd10) begin
      r.tens = 4'd1; r.units = 4'(v - 6'd10);
    end else begin
      r.tens = 4'd0; r.units = v[3:0];
    end
    return r;
  endfunction

endpackage

FILE: sv/wcd_digit_cell.sv
// One decimal digit of the time counter, rippling its carry to the next cell.
module wcd_digit_cell (
  input  logic                clk,
  input  logic                rst,
  input  wcd_pkg::digit_ctrl_t ctrl,
  input  logic [3:0]          load_digit,
  input  logic [3:0]          max_digit,
  output logic [3:0]          digit,
  output logic                carry
);

  logic [3:0] digit_next;

  assign carry = ctrl.step && (digit == max_digit);

  always_comb begin
    digit_next = digit;
    if (ctrl.clear) begin
      digit_next = 4'd0;
    end else if (ctrl.load) begin
      digit_next = load_digit;
    end else if (ctrl.step) begin
      digit_next = (digit == max_digit) ? 4'd0 : 4'(digit + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit <= 4'd0;
    end else begin
      digit <= digit_next;
    end
  end

endmodule

FILE: sv/wcd_char_cell.sv
// One character slot of the output line; shifts towards the head as characters leave.
module wcd_char_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  wcd_pkg::char_link_t load_link,
  input  logic                shift,
  input  wcd_pkg::char_link_t from_next,
  output wcd_pkg::char_link_t slot
);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else if (load) begin
      slot <= load_link;
    end else if (shift) begin
      slot <= from_next;
    end
  end

endmodule

FILE: sv/wall_clock_hhmmss_display.sv
// Top level of the time-of-day clock with an HH:MM:SS character display.
//
// Request channel (cmd_valid / cmd_stall): kind selects reset-and-start, set-and-start,
// stop or a one-second tick; set_hours/minutes/seconds matter only for a set request.
// Character channel (char_valid / char_stall): display_char carries "HH:MM:SS" and a
// newline, one character per transfer, last_char high on the newline.
//
// Time is held in a row of six decimal digit cells (seconds units up to hours tens),
// each passing its carry to the next; the hour cells wrap together after 23.
// A running tick copies the digits into a row of nine character cells and steps the
// counter in the same cycle. The character row shifts one place towards the head per
// cycle unless the head character is stalled; the head cell is the output register, so
// the first character is offered the cycle after the tick is taken.
// The next tick is taken as soon as only the final character of the previous line is
// left and leaving; the character row thus limits how often ticks are taken.
// Reset, stop and halted ticks are accepted whenever no set is in progress. A set request
// runs through the PH_SEC, PH_MIN and PH_HOUR phases, which normalise seconds, minutes and
// hours mod 60/60/24 and load the digits, and cmd_stall is held high meanwhile.
// A stalled character holds; ticks then wait on cmd_stall while the line is full.
// After rst the count is zero, the clock is halted and no character is pending.
module wall_clock_hhmmss_display (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic [1:0] kind,
  input  logic [6:0] set_hours,
  input  logic [6:0] set_minutes,
  input  logic [6:0] set_seconds,
  output logic       char_valid,
  input  logic       char_stall,
  output logic [6:0] display_char,
  output logic       last_char
);

  localparam int unsigned LineLen   = wcd_pkg::LINE_LEN;
  localparam int unsigned NumDigits = wcd_pkg::NUM_DIGITS;

  wcd_pkg::kind_t      cmd_kind;
  wcd_pkg::set_phase_t phase, phase_next;

  logic       running;
  logic       accept;
  logic       tick_go;
  logic       cmd_clear;
  logic       hour_wrap;
  logic       line_free;
  logic       shift;

  // Set normalisation registers (payload, no reset)
  logic [6:0] set_s;
  logic [7:0] set_m;
  logic [7:0] set_h;

  wcd_pkg::mod60_t sec_norm;
  wcd_pkg::mod60_t min_norm;
  wcd_pkg::bcd_t   sec_bcd;
  wcd_pkg::bcd_t   min_bcd;
  wcd_pkg::bcd_t   hour_bcd;

  // Digit row: 0 seconds units .. 5 hours tens
  wcd_pkg::digit_ctrl_t digit_ctrl [NumDigits];
  logic [3:0]           digit      [NumDigits];
  logic [3:0]           load_digit [NumDigits];
  logic [3:0]           max_digit  [NumDigits];
  logic                 carry      [NumDigits];

  // Character row: 0 is the head
  wcd_pkg::char_link_t slot      [LineLen];
  wcd_pkg::char_link_t next_link [LineLen];
  wcd_pkg::char_link_t line_link [LineLen];

  assign cmd_kind = wcd_pkg::kind_t'(kind);

  // Line may be loaded when at most the head remains and it leaves this cycle
  assign line_free = !slot[1].valid && (!slot[0].valid || !char_stall);
  assign shift     = !slot[0].valid || !char_stall;

  assign cmd_stall = (phase != wcd_pkg::PH_IDLE)
                  || ((cmd_kind == wcd_pkg::KIND_TICK) && running && !line_free);
  assign accept    = cmd_valid && !cmd_stall;
  assign tick_go   = accept && (cmd_kind == wcd_pkg::KIND_TICK) && running;
  assign cmd_clear = accept && ((cmd_kind == wcd_pkg::KIND_RESET)
                             || (cmd_kind == wcd_pkg::KIND_STOP));

  // ---------------------------------------------------------------------------
  // Run flag
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else if (accept) begin
      case (cmd_kind)
        wcd_pkg::KIND_RESET: running <= 1'b1;
        wcd_pkg::KIND_SET:   running <= 1'b1;
        wcd_pkg::KIND_STOP:  running <= 1'b0;
        default:             running <= running;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Set sequencer: carry seconds into minutes, minutes into hours, then load
  // ---------------------------------------------------------------------------
  assign sec_norm = wcd_pkg::mod60({1'b0, set_s});
  assign min_norm = wcd_pkg::mod60(set_m);
  assign sec_bcd  = wcd_pkg::to_bcd(set_s[5:0]);
  assign min_bcd  = wcd_pkg::to_bcd(set_m[5:0]);
  assign hour_bcd = wcd_pkg::to_bcd({1'b0, wcd_pkg::mod24(set_h)});

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= wcd_pkg::PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      wcd_pkg::PH_IDLE: begin
        if (accept && (cmd_kind == wcd_pkg::KIND_SET)) phase_next = wcd_pkg::PH_SEC;
      end
      wcd_pkg::PH_SEC:  phase_next = wcd_pkg::PH_MIN;
      wcd_pkg::PH_MIN:  phase_next = wcd_pkg::PH_HOUR;
      wcd_pkg::PH_HOUR: phase_next = wcd_pkg::PH_IDLE;
      default:          phase_next = wcd_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (phase)
      wcd_pkg::PH_IDLE: begin
        if (accept && (cmd_kind == wcd_pkg::KIND_SET)) begin
          set_s <= set_seconds;
          set_m <= {1'b0, set_minutes};
          set_h <= {1'b0, set_hours};
        end
      end
      wcd_pkg::PH_SEC: begin
        set_s <= {1'b0, sec_norm.rem};
        set_m <= 8'(set_m + {6'd0, sec_norm.quot});
      end
      wcd_pkg::PH_MIN: begin
        set_m <= {2'b00, min_norm.rem};
        set_h <= 8'(set_h + {6'd0, min_norm.quot});
      end
      default: begin
        set_s <= set_s;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Digit row
  // ---------------------------------------------------------------------------
  assign load_digit[0] = sec_bcd.units;
  assign load_digit[1] = sec_bcd.tens;
  assign load_digit[2] = min_bcd.units;
  assign load_digit[3] = min_bcd.tens;
  assign load_digit[4] = hour_bcd.units;
  assign load_digit[5] = hour_bcd.tens;

  assign max_digit[0] = wcd_pkg::MAX_UNITS;
  assign max_digit[1] = wcd_pkg::MAX_TENS_SM;
  assign max_digit[2] = wcd_pkg::MAX_UNITS;
  assign max_digit[3] = wcd_pkg::MAX_TENS_SM;
  assign max_digit[4] = wcd_pkg::MAX_UNITS;
  assign max_digit[5] = wcd_pkg::MAX_TENS_HR;

  // 23:59:59 rolls to 00:00:00: both hour cells cleared together
  assign hour_wrap = carry[3] && (digit[4] == wcd_pkg::HOUR_WRAP_UNI)
                              && (digit[5] == wcd_pkg::HOUR_WRAP_TEN);

  for (genvar i = 0; i < NumDigits; i++) begin : g_digit
    if (i == 0) begin : g_first
      assign digit_ctrl[i].step = tick_go;
    end else begin : g_rest
      assign digit_ctrl[i].step = carry[i-1];
    end
    assign digit_ctrl[i].load  = (phase == wcd_pkg::PH_HOUR);
    assign digit_ctrl[i].clear = cmd_clear || ((i >= 4) && hour_wrap);

    wcd_digit_cell u_digit (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (digit_ctrl[i]),
      .load_digit (load_digit[i]),
      .max_digit  (max_digit[i]),
      .digit      (digit[i]),
      .carry      (carry[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Character row
  // ---------------------------------------------------------------------------
  always_comb begin
    line_link[0] = '{valid: 1'b1, ch: 7'(wcd_pkg::CHAR_ZERO + {3'd0, digit[5]}), last: 1'b0};
    line_link[1] = '{valid: 1'b1, ch: 7'(wcd_pkg::CHAR_ZERO + {3'd0, digit[4]}), last: 1'b0};
    line_link[2] = '{valid: 1'b1, ch: wcd_pkg::CHAR_COLON, last: 1'b0};
    line_link[3] = '{valid: 1'b1, ch: 7'(wcd_pkg::CHAR_ZERO + {3'd0, digit[3]}), last: 1'b0};
    line_link[4] = '{valid: 1'b1, ch: 7'(wcd_pkg::CHAR_ZERO + {3'd0, digit[2]}), last: 1'b0};
    line_link[5] = '{valid: 1'b1, ch: wcd_pkg::CHAR_COLON, last: 1'b0};
    line_link[6] = '{valid: 1'b1, ch: 7'(wcd_pkg::CHAR_ZERO + {3'd0, digit[1]}), last: 1'b0};
    line_link[7] = '{valid: 1'b1, ch: 7'(wcd_pkg::CHAR_ZERO + {3'd0, digit[0]}), last: 1'b0};
    line_link[8] = '{valid: 1'b1, ch: wcd_pkg::CHAR_NEWLINE, last: 1'b1};
  end

  for (genvar i = 0; i < LineLen; i++) begin : g_char
    if (i == LineLen - 1) begin : g_tail
      assign next_link[i] = '{valid: 1'b0, ch: wcd_pkg::CHAR_ZERO, last: 1'b0};
    end else begin : g_body
      assign next_link[i] = slot[i+1];
    end

    wcd_char_cell u_char (
      .clk       (clk),
      .rst       (rst),
      .load      (tick_go),
      .load_link (line_link[i]),
      .shift     (shift),
      .from_next (next_link[i]),
      .slot      (slot[i])
    );
  end

  assign char_valid   = slot[0].valid;
  assign display_char = slot[0].ch;
  assign last_char    = slot[0].last;

endmodule
